// File: hdl/fat_short_name_to_utf8_core_assert.svh
// Assertion macros shared by the checker of the short-name converter.
// Depends on nothing; included by fsu_checker.sv.
`ifndef FAT_SHORT_NAME_TO_UTF8_CORE_ASSERT_SVH
`define FAT_SHORT_NAME_TO_UTF8_CORE_ASSERT_SVH

// Implication checked at every edge out of reset.
`define FSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a non-overlapping consequent, checked with reset included.
`define FSU_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fsu_pkg.sv
// Shared types, constants and the CP850 upper-half table for the
// short-name to UTF-8 converter. No dependencies.
package fsu_pkg;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] DOT_BYTE   = 8'h2E;
    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam logic [3:0] POS_EXT    = 4'd8;
    localparam logic [3:0] POS_LAST   = 4'd10;
    localparam logic [2:0] PEND_MAX   = 3'd7;

    // One input item's worth of output: a repeated head byte (held spaces
    // or the dot), up to three character bytes, then an optional terminator.
    typedef struct packed {
        logic [2:0]       head_cnt;
        logic [7:0]       head_byte;
        logic [1:0]       ch_len;
        logic [2:0][7:0]  ch;
        logic             nul;
        logic [3:0]       total;
    } t_run;

    localparam logic [15:0] CP850_HIGH [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
        16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
        16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
        16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
        16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
        16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
        16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
        16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
    };

endpackage

// File: hdl/fsu_if.sv
// Valid/ready channel interfaces of the short-name converter: name bytes in,
// UTF-8 bytes out. No dependencies.
interface fsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       lower_base;
    logic       lower_ext;

    modport source (output valid, name_byte, lower_base, lower_ext, input ready);
    modport sink   (input valid, name_byte, lower_base, lower_ext, output ready);
    modport monitor (input valid, ready, name_byte, lower_base, lower_ext);
endinterface

interface fsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, out_byte, run_last, input ready);
    modport sink   (input valid, out_byte, run_last, output ready);
    modport monitor (input valid, ready, out_byte, run_last);
endinterface

// File: hdl/fsu_decode.sv
// Input stage: tracks the position within the 11-byte name, held spaces and
// the dot flag, and turns each accepted item into a run descriptor. Uses fsu_pkg.
module fsu_decode import fsu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fsu_in_if.sink i_in,
    input  logic   i_take,
    output logic   o_run_load,
    output t_run   o_run
);

    logic [3:0]  r_pos, n_pos;
    logic [2:0]  r_pend, n_pend;
    logic        r_ext, n_ext;
    logic        accept;
    logic        is_space;
    logic        ext_now;
    logic        emit_ch;
    logic        lower_sel;
    logic [7:0]  b;
    logic [7:0]  ascii;
    logic [15:0] cp;
    t_run        run;

    assign i_in.ready = i_take;
    assign accept     = i_in.valid && i_take;
    assign b          = i_in.name_byte;
    assign is_space   = (b == SPACE_BYTE);
    assign cp         = CP850_HIGH[b[6:0]];

    always_comb begin
        n_pos     = r_pos;
        n_pend    = r_pend;
        n_ext     = r_ext;
        run       = '0;
        run.head_byte = SPACE_BYTE;
        emit_ch   = 1'b0;
        ext_now   = r_ext;
        lower_sel = i_in.lower_ext;
        ascii     = b;

        if (!r_pos[3]) begin
            lower_sel = i_in.lower_base;
            if (is_space) begin
                if (r_pend != PEND_MAX) begin
                    n_pend = r_pend + 3'd1;
                end
            end else begin
                run.head_cnt = r_pend;
                n_pend       = '0;
                emit_ch      = 1'b1;
            end
        end else begin
            if (r_pos == POS_EXT) begin
                n_pend = '0;
                if (!is_space) begin
                    ext_now       = 1'b1;
                    run.head_cnt  = 3'd1;
                    run.head_byte = DOT_BYTE;
                end
            end
            n_ext   = ext_now;
            emit_ch = ext_now && !is_space;
        end

        if (lower_sel && b >= 8'h41 && b <= 8'h5A) begin
            ascii = b | 8'h20;
        end

        if (emit_ch) begin
            if (!b[7]) begin
                run.ch_len = 2'd1;
                run.ch[0]  = ascii;
            end else if (cp[15:11] == 5'd0) begin
                run.ch_len = 2'd2;
                run.ch[0]  = {3'b110, cp[10:6]};
                run.ch[1]  = {2'b10, cp[5:0]};
            end else begin
                run.ch_len = 2'd3;
                run.ch[0]  = {4'b1110, cp[15:12]};
                run.ch[1]  = {2'b10, cp[11:6]};
                run.ch[2]  = {2'b10, cp[5:0]};
            end
        end

        if (r_pos >= POS_LAST) begin
            run.nul = 1'b1;
            n_pos   = '0;
            n_pend  = '0;
            n_ext   = 1'b0;
        end else begin
            n_pos = r_pos + 4'd1;
        end

        run.total = {1'b0, run.head_cnt} + {2'b00, run.ch_len} + {3'b000, run.nul};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pend <= '0;
            r_ext  <= 1'b0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_pend <= n_pend;
            r_ext  <= n_ext;
        end
    end

    // Items that only hold or skip a space produce no run at all, except the last item of the name.
    assign o_run_load = accept && (run.total != 4'd0);
    assign o_run      = run;

endmodule

// File: hdl/fsu_emit.sv
// Output stage: holds one run descriptor and plays it out one byte per
// cycle into the output register unless the output stalls. Uses fsu_pkg.
module fsu_emit import fsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_run_load,
    input  t_run      i_run,
    output logic      o_take,
    fsu_out_if.source o_out
);

    logic       r_run_valid;
    t_run       r_run, n_run;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       adv;
    logic       run_done;
    logic [7:0] cur_byte;

    assign adv      = r_run_valid && (!r_out_valid || o_out.ready);
    assign run_done = adv && (r_run.total == 4'd1);
    // The run register refills in the same cycle its last byte moves out.
    assign o_take   = !r_run_valid || run_done;

    always_comb begin
        n_run    = r_run;
        n_idx    = r_idx;
        cur_byte = NUL_BYTE;
        if (r_run.head_cnt != 3'd0) begin
            cur_byte       = r_run.head_byte;
            n_run.head_cnt = r_run.head_cnt - 3'd1;
        end else if (r_idx < r_run.ch_len) begin
            cur_byte = r_run.ch[r_idx];
            n_idx    = r_idx + 2'd1;
        end
        n_run.total = r_run.total - 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_run_load) begin
                r_run_valid <= 1'b1;
            end else if (run_done) begin
                r_run_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_load) begin
            r_run <= i_run;
            r_idx <= '0;
        end else if (adv) begin
            r_run <= n_run;
            r_idx <= n_idx;
        end
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_run.total == 4'd1);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

endmodule

// File: hdl/fat_short_name_to_utf8_core.sv
// Top level of the FAT 8.3 short-name to UTF-8 converter.
// Depends on fsu_pkg, fsu_if, fsu_decode and fsu_emit.
//
//  channel  | dir | item                                   | handshake
//  ---------+-----+----------------------------------------+-----------
//  i_in     | in  | name_byte, lower_base, lower_ext       | valid/ready
//  o_out    | out | out_byte, run_last                     | valid/ready
//
// Each accepted item is decoded combinationally into a run of 0 to 10 bytes;
// the run is then played out one byte per cycle unless the output stalls.
// The next item is accepted in the cycle the current run's last byte leaves.
// Reset is synchronous and active low; it clears position, held spaces,
// the dot flag and both valid flags. Output stalls hold the run in place.
module fat_short_name_to_utf8_core import fsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsu_in_if.sink    i_in,
    fsu_out_if.source o_out
);

    logic take;
    logic run_load;
    t_run run;

    fsu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_take     (take),
        .o_run_load (run_load),
        .o_run      (run)
    );

    fsu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run_load (run_load),
        .i_run      (run),
        .o_take     (take),
        .o_out      (o_out)
    );

endmodule

// File: hdl/fsu_checker.sv
// Port-level checker for the output channel of the short-name converter,
// bound to the top level. Depends on fat_short_name_to_utf8_core_assert.svh.
`include "fat_short_name_to_utf8_core_assert.svh"

module fsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic       i_last
);

    // A byte still waiting downstream must stay offered.
    `FSU_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, ##1 i_valid, "item dropped")

    `FSU_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !i_valid, "output valid right after reset")

    // A UTF-8 lead byte is never the last byte of its run.
    `FSU_ASSERT_IMPL(a_lead_cont, i_clk, i_rst_n, i_valid && i_byte >= 8'hC0, !i_last, "lead last")

endmodule

bind fat_short_name_to_utf8_core fsu_checker u_fsu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_last  (o_out.run_last)
);
